>>> hdl/regex_dot_star_match_stream_assert.svh
// Assertion macros for the streaming dot-star matcher.
// Included by the RTL files that carry concurrent assertions.
// Synthesis builds define SYNTH so that the macros expand to nothing.
`ifndef REGEX_DOT_STAR_MATCH_STREAM_ASSERT_SVH
`define REGEX_DOT_STAR_MATCH_STREAM_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RDSM_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("rdsm assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RDSM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("rdsm assertion failed");
`else
`define RDSM_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons)
`define RDSM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif

`endif

>>> hdl/rdsm_pkg.sv
// Package for the streaming dot-star matcher: sizes, register indexes
// and the wildcard byte code. No dependencies.
`timescale 1ns / 1ps

package rdsm_pkg;

    localparam int MAX_TOKENS_DEFAULT = 32;
    localparam int CFG_TOKENS = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TOKEN_COUNT_W = 6;

    localparam logic [7:0] ANY_BYTE = 8'd46;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STAR_MASK = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_COUNT = 3'd5;

endpackage

>>> hdl/regex_dot_star_match_stream.sv
// Streaming full-string matcher for patterns of literal bytes, '.' and '*'.
// Depends on rdsm_pkg and the assertion macros in the included header.
// The set of reachable pattern positions is updated bit-parallel per byte.
//
//   Channel   Signals                              Direction  Item
//   text      text_valid/text_ready + 3 fields     in         one text byte
//   result    result_valid/result_ready + 2 fields out        one match flag
//   cfg       cfg_write, cfg_index, cfg_data       in         register write
//
// One item is taken every cycle unless a stall blocks it; each result is offered
// after its item is taken (input register, then result register).
// The update of the position set, with two log-depth star closures, sits
// between those two registers and sets the clock period.
// Reset clears the position set, the configuration and both valid flags.
// A stalled result holds the input register; the block still takes an item
// while a finished result waits, as long as that register is empty.
`timescale 1ns / 1ps
`include "regex_dot_star_match_stream_assert.svh"

module regex_dot_star_match_stream #(
    parameter int MAX_TOKENS = rdsm_pkg::MAX_TOKENS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             text_valid,
    output logic                             text_ready,
    input  logic [7:0]                       text_byte,
    input  logic                             first_of_text,
    input  logic                             last_of_text,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic                             whole_match,
    output logic                             end_of_text,
    input  logic                             cfg_write,
    input  logic [rdsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rdsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rdsm_pkg::*;

    localparam int W = MAX_TOKENS + 1;
    localparam int N_W = $clog2(MAX_TOKENS + 1);
    localparam int LEVELS = $clog2(W);

    logic [3:0][CFG_DATA_W-1:0] pattern_reg;
    logic [CFG_TOKENS-1:0]      star_mask_reg;
    logic [TOKEN_COUNT_W-1:0]   token_count_reg;

    logic       in_valid_reg;
    logic [7:0] text_byte_reg;
    logic       first_reg;
    logic       last_reg;

    logic       result_valid_reg;
    logic       whole_match_reg;
    logic       end_of_text_reg;
    logic       whole_match_next;

    logic [W-1:0] active_reg;
    logic [W-1:0] active_next;

    logic                  advance;
    logic [N_W-1:0]        n_tokens;
    logic [W-1:0]          keep_mask;
    logic [W-1:0]          end_mask;
    logic [MAX_TOKENS-1:0] live_mask;
    logic [MAX_TOKENS-1:0] tok_star;
    logic [MAX_TOKENS-1:0] tok_hit;
    logic [W-1:0]          prop;
    logic [W-1:0]          start_set;
    logic [W-1:0]          closed_set;
    logic [MAX_TOKENS-1:0] step_hit;
    logic [W-1:0]          raw_next;

    // Marks every position reachable from a seed by skipping starred tokens.
    // Bit j of pass allows a move from position j-1 into position j.
    function automatic logic [W-1:0] star_closure(input logic [W-1:0] seed,
                                                  input logic [W-1:0] pass_in);
        logic [W-1:0] gen;
        logic [W-1:0] pass;
        logic [W-1:0] gen_n;
        logic [W-1:0] pass_n;
        gen = seed;
        pass = pass_in;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            for (int j = 0; j < W; j++)
            begin
                if (j >= (1 << lvl))
                begin
                    gen_n[j] = gen[j] | (pass[j] & gen[j - (1 << lvl)]);
                    pass_n[j] = pass[j] & pass[j - (1 << lvl)];
                end
                else
                begin
                    gen_n[j] = gen[j];
                    pass_n[j] = 1'b0;
                end
            end
            gen = gen_n;
            pass = pass_n;
        end
        return gen;
    endfunction

    assign advance = in_valid_reg && (!result_valid_reg || result_ready);
    assign text_ready = !in_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign whole_match = whole_match_reg;
    assign end_of_text = end_of_text_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            star_mask_reg <= '0;
            token_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                begin
                    pattern_reg[cfg_index[1:0]] <= cfg_data;
                end
                REG_STAR_MASK:
                begin
                    star_mask_reg <= cfg_data[CFG_TOKENS-1:0];
                end
                REG_TOKEN_COUNT:
                begin
                    token_count_reg <= cfg_data[TOKEN_COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (int'(token_count_reg) > MAX_TOKENS)
        begin
            n_tokens = N_W'(MAX_TOKENS);
        end
        else
        begin
            n_tokens = N_W'(token_count_reg);
        end
        for (int j = 0; j < W; j++)
        begin
            keep_mask[j] = (32'(j) <= 32'(n_tokens));
            end_mask[j] = (32'(j) == 32'(n_tokens));
        end
        for (int j = 0; j < MAX_TOKENS; j++)
        begin
            live_mask[j] = (32'(j) < 32'(n_tokens));
        end
    end

    for (genvar j = 0; j < MAX_TOKENS; j++)
    begin : g_token
        if (j < CFG_TOKENS)
        begin : g_cfg
            assign tok_star[j] = star_mask_reg[j];
            assign tok_hit[j] = (pattern_reg[j / 8][(j % 8) * 8 +: 8] == text_byte_reg)
                || (pattern_reg[j / 8][(j % 8) * 8 +: 8] == ANY_BYTE);
        end
        else
        begin : g_zero
            assign tok_star[j] = 1'b0;
            assign tok_hit[j] = (text_byte_reg == 8'd0);
        end
    end

    always_comb
    begin
        prop = {tok_star & live_mask, 1'b0};
        start_set = (first_reg ? W'(1) : active_reg) & keep_mask;
        closed_set = star_closure(start_set, prop);
        step_hit = closed_set[MAX_TOKENS-1:0] & live_mask & tok_hit;
        raw_next = {1'b0, step_hit & tok_star} | {step_hit & ~tok_star, 1'b0};
        active_next = star_closure(raw_next, prop);
        whole_match_next = |(active_next & end_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            active_reg <= '0;
        end
        else
        begin
            if (text_ready)
            begin
                in_valid_reg <= text_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                active_reg <= active_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            text_byte_reg <= text_byte;
            first_reg <= first_of_text;
            last_reg <= last_of_text;
        end
        if (advance)
        begin
            whole_match_reg <= whole_match_next;
            end_of_text_reg <= last_reg;
        end
    end

    `RDSM_ASSERT_IMPL(a_stall_cause, clk, rst_n, !text_ready,
        in_valid_reg && result_valid_reg && !result_ready)
    `RDSM_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, result_valid_reg)
    `RDSM_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance, $stable(active_reg))
    `RDSM_ASSERT_NEXT(a_empty_pattern, clk, rst_n, advance && (token_count_reg == '0),
        !whole_match_reg)

endmodule
